// ----- rtl/core/tws_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types for the text word statistics block.
// ----------------------------------------------------------------------------
package tws_pkg;

  // one classified text byte travelling from the front end to the back end
  typedef struct packed {
    logic       eot;
    logic       delim;
    logic       newline;
    logic       vowel;
    logic [7:0] text_byte;
  } tws_item_t;

  // one report row as registered in the back end
  typedef struct packed {
    logic        last_row;
    logic [31:0] total_vowels;
    logic [31:0] total_words;
    logic [31:0] total_lines;
    logic [31:0] total_chars;
    logic [3:0]  longest_length;
    logic [7:0]  longest_byte;
    logic [31:0] bin_count;
    logic [3:0]  length_index;
  } tws_row_t;

endpackage
`default_nettype wire

// ----- rtl/core/tws_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tws_front
// Accepts text transactions, classifies each byte and queues it.
// ----------------------------------------------------------------------------
module tws_front
  import tws_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic      in_eot_i,
  output logic           item_valid_o,
  output tws_item_t      item_o,
  input  wire logic      item_pop_i
);

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChPeriod  = 8'h2e;
  localparam logic [7:0] ChComma   = 8'h2c;
  localparam logic [7:0] ChExcl    = 8'h21;
  localparam logic [7:0] ChA       = 8'h61;
  localparam logic [7:0] ChE       = 8'h65;
  localparam logic [7:0] ChI       = 8'h69;
  localparam logic [7:0] ChO       = 8'h6f;
  localparam logic [7:0] ChU       = 8'h75;
  localparam logic [7:0] CaseBit   = 8'h20;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  tws_item_t            queue_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]        count_q, count_d;
  tws_item_t            cls;
  logic [7:0]           low_byte;
  logic                 push;

  always_comb begin
    // folding to lower case only matters for letters, so OR-ing is enough
    low_byte      = in_byte_i | CaseBit;
    cls.eot       = in_eot_i;
    cls.text_byte = in_byte_i;
    cls.newline   = (in_byte_i == ChNewline);
    cls.delim     = (in_byte_i == ChSpace) || (in_byte_i == ChNewline) ||
                    (in_byte_i == ChTab) || (in_byte_i == ChPeriod) ||
                    (in_byte_i == ChComma) || (in_byte_i == ChExcl);
    cls.vowel     = (low_byte == ChA) || (low_byte == ChE) || (low_byte == ChI) ||
                    (low_byte == ChO) || (low_byte == ChU);
  end

  assign in_ready_o   = (count_q != (PtrW + 1)'(Depth));
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (item_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !item_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && item_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tws_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tws_back
// Applies queued bytes to the counters, word buffers and histogram, and
// walks the histogram into report rows on end of text.
// ----------------------------------------------------------------------------
module tws_back
  import tws_pkg::*;
#(
  parameter int MAX_WORD_LEN = 15,
  parameter int COUNT_BITS   = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic item_valid_i,
  input  tws_item_t item_i,
  output logic      item_pop_o,
  output logic      row_valid_o,
  input  wire logic row_ready_i,
  output tws_row_t  row_o
);

  localparam int LW = $clog2(MAX_WORD_LEN + 1);
  localparam int AW = $clog2(MAX_WORD_LEN);

  localparam logic [1:0] SRun = 2'd0;
  localparam logic [1:0] SWb  = 2'd1;
  localparam logic [1:0] SRd  = 2'd2;
  localparam logic [1:0] SOut = 2'd3;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  logic [1:0]            state_q, state_d;
  logic [COUNT_BITS-1:0] chars_q, chars_d;
  logic [COUNT_BITS-1:0] lines_q, lines_d;
  logic [COUNT_BITS-1:0] vowels_q, vowels_d;
  logic [COUNT_BITS-1:0] words_q, words_d;
  logic [LW-1:0]         cur_len_q, cur_len_d;
  logic [LW-1:0]         long_len_q, long_len_d;
  logic [7:0]            cur_word_q [MAX_WORD_LEN];
  logic [7:0]            long_word_q [MAX_WORD_LEN];
  logic [7:0]            long_word_d [MAX_WORD_LEN];
  logic                  cw_we;
  logic [AW-1:0]         idx_q, idx_d;
  logic                  inc_pend_q, inc_pend_d;
  logic [AW-1:0]         inc_addr_q, inc_addr_d;
  logic [AW-1:0]         rd_addr;
  logic [MAX_WORD_LEN-1:0] hist_vld_q, hist_vld_d;
  logic [COUNT_BITS-1:0] hist_mem [MAX_WORD_LEN];
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  rd_vld_q;
  logic [COUNT_BITS-1:0] bin_val;
  logic                  do_close;
  logic                  load_row;
  logic                  clear_all;
  logic                  row_valid_q, row_valid_d;
  tws_row_t              row_q, row_d;

  assign bin_val     = rd_vld_q ? rd_data_q : '0;
  assign item_pop_o  = (state_q == SRun) && item_valid_i;
  assign rd_addr     = (state_q != SRun) ? idx_q : AW'(cur_len_q - 1'b1);
  assign row_valid_o = row_valid_q;
  assign row_o       = row_q;

  always_comb begin
    state_d     = state_q;
    chars_d     = chars_q;
    lines_d     = lines_q;
    vowels_d    = vowels_q;
    words_d     = words_q;
    cur_len_d   = cur_len_q;
    long_len_d  = long_len_q;
    long_word_d = long_word_q;
    idx_d       = idx_q;
    inc_pend_d  = 1'b0;
    inc_addr_d  = inc_addr_q;
    hist_vld_d  = hist_vld_q;
    row_valid_d = row_valid_q;
    row_d       = row_q;
    cw_we       = 1'b0;
    do_close    = 1'b0;
    load_row    = 1'b0;
    clear_all   = 1'b0;

    if (inc_pend_q) begin
      hist_vld_d[inc_addr_q] = 1'b1;
    end
    if (row_ready_i) begin
      row_valid_d = 1'b0;
    end

    unique case (state_q)
      SRun: begin
        if (item_valid_i) begin
          if (item_i.eot) begin
            do_close = 1'b1;
            state_d  = SWb;
          end else begin
            chars_d = sat_inc(chars_q);
            if (item_i.newline) begin
              lines_d = sat_inc(lines_q);
            end
            if (item_i.delim) begin
              do_close = 1'b1;
            end else begin
              if (item_i.vowel) begin
                vowels_d = sat_inc(vowels_q);
              end
              if (cur_len_q < LW'(MAX_WORD_LEN)) begin
                cw_we     = 1'b1;
                cur_len_d = cur_len_q + 1'b1;
              end
            end
          end
        end
      end
      SWb: begin
        state_d = SRd;
      end
      SRd: begin
        state_d = SOut;
      end
      SOut: begin
        if (!row_valid_q || row_ready_i) begin
          load_row = 1'b1;
          if (idx_q == AW'(MAX_WORD_LEN - 1)) begin
            clear_all = 1'b1;
            state_d   = SRun;
          end else begin
            state_d = SRd;
          end
        end
      end
      default: state_d = SRun;
    endcase

    if (do_close && (cur_len_q != '0)) begin
      inc_pend_d = 1'b1;
      inc_addr_d = AW'(cur_len_q - 1'b1);
      words_d    = sat_inc(words_q);
      if (cur_len_q > long_len_q) begin
        long_len_d = cur_len_q;
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
          long_word_d[k] = (LW'(k) < cur_len_q) ? cur_word_q[k] : 8'h00;
        end
      end
    end
    if (do_close) begin
      cur_len_d = '0;
    end

    if (load_row) begin
      row_valid_d          = 1'b1;
      row_d.length_index   = 4'({1'b0, idx_q} + 1'b1);
      row_d.bin_count      = 32'(bin_val);
      row_d.longest_byte   = long_word_q[0];
      row_d.longest_length = 4'(long_len_q);
      row_d.total_chars    = 32'(chars_q);
      row_d.total_lines    = 32'(lines_q);
      row_d.total_words    = 32'(words_q);
      row_d.total_vowels   = 32'(vowels_q);
      row_d.last_row       = (idx_q == AW'(MAX_WORD_LEN - 1));
      idx_d                = idx_q + 1'b1;
      // past the end of the word the buffer already holds zeros
      for (int k = 0; k < MAX_WORD_LEN - 1; k++) begin
        long_word_d[k] = long_word_q[k+1];
      end
      long_word_d[MAX_WORD_LEN-1] = 8'h00;
    end

    if (clear_all) begin
      chars_d     = '0;
      lines_d     = '0;
      vowels_d    = '0;
      words_d     = '0;
      long_len_d  = '0;
      idx_d       = '0;
      hist_vld_d  = '0;
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
        long_word_d[k] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SRun;
      chars_q     <= '0;
      lines_q     <= '0;
      vowels_q    <= '0;
      words_q     <= '0;
      cur_len_q   <= '0;
      long_len_q  <= '0;
      idx_q       <= '0;
      inc_pend_q  <= 1'b0;
      hist_vld_q  <= '0;
      rd_vld_q    <= 1'b0;
      row_valid_q <= 1'b0;
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
        long_word_q[k] <= 8'h00;
      end
    end else begin
      state_q     <= state_d;
      chars_q     <= chars_d;
      lines_q     <= lines_d;
      vowels_q    <= vowels_d;
      words_q     <= words_d;
      cur_len_q   <= cur_len_d;
      long_len_q  <= long_len_d;
      idx_q       <= idx_d;
      inc_pend_q  <= inc_pend_d;
      hist_vld_q  <= hist_vld_d;
      rd_vld_q    <= hist_vld_q[rd_addr];
      row_valid_q <= row_valid_d;
      long_word_q <= long_word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inc_addr_q <= inc_addr_d;
    row_q      <= row_d;
    if (cw_we) begin
      cur_word_q[AW'(cur_len_q)] <= item_i.text_byte;
    end
  end

  // histogram bins: registered read-modify-write
  always_ff @(posedge clk_i) begin
    if (inc_pend_q) begin
      hist_mem[inc_addr_q] <= sat_inc(bin_val);
    end
    rd_data_q <= hist_mem[rd_addr];
  end

`ifndef ASSERT_OFF
  a_no_back_to_back_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inc_pend_q |=> !inc_pend_q)
    else $error("histogram increments in consecutive cycles");

  a_cur_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_len_q <= LW'(MAX_WORD_LEN))
    else $error("open word length beyond maximum");

  a_no_pop_in_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SRun) |-> !item_pop_o)
    else $error("queue popped during report");

  a_last_row_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid_q && row_q.last_row) |-> (row_q.length_index == 4'(MAX_WORD_LEN)))
    else $error("last row flag on wrong length");

  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_all |=> (chars_q == '0) && (hist_vld_q == '0) && (long_len_q == '0))
    else $error("state not cleared after report");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/text_word_statistics.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_word_statistics
// Word, line, character and vowel statistics with a word length histogram.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one text byte per transaction in s_axis_tdata. A
//   transaction with s_axis_tlast high carries no text; it closes the open
//   word and starts the report.
//   Master stream: MAX_WORD_LEN report rows, one per word length from 1
//   upwards; m_axis_tlast marks the row for length MAX_WORD_LEN.
// Timing:
//   Text bytes are taken at one per cycle while the queue has room; a
//   four-entry queue sits between the byte classifier and the
//   counter/histogram back end. A byte is written into the queue and
//   reaches the counters when the back end pops it. After the end
//   transaction a write-back state runs, then a read state and an output
//   state per row, set by the registered read of the histogram memory.
//   Input is held off once the queue fills during the report.
// Reset and stalls:
//   Reset clears all counters and the histogram valid bits at once, so no
//   clearing pass is needed; the state is cleared again after each report.
//   When m_axis_tready is low the current row is held and the walk pauses.
// ----------------------------------------------------------------------------
module text_word_statistics
  import tws_pkg::*;
#(
  parameter int MAX_WORD_LEN = 15,
  parameter int COUNT_BITS   = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // text_byte
  input  wire logic         s_axis_tlast,  // end_of_text
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // length_index, bin_count, longest_byte, longest_length, total_chars,
  // total_lines, total_words, total_vowels
  output logic [175:0]      m_axis_tdata,
  output logic              m_axis_tlast   // last_row
);

  logic      item_valid;
  logic      item_pop;
  tws_item_t item;
  tws_row_t  row;

  tws_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_eot_i     (s_axis_tlast),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  tws_back #(
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .row_valid_o  (m_axis_tvalid),
    .row_ready_i  (m_axis_tready),
    .row_o        (row)
  );

  assign m_axis_tdata = {row.total_vowels, row.total_words, row.total_lines,
                         row.total_chars, row.longest_length, row.longest_byte,
                         row.bin_count, row.length_index};
  assign m_axis_tlast = row.last_row;

endmodule
`default_nettype wire
